// File: rtl/core/tbrl_pkg.sv
`timescale 1ns / 1ps

package tbrl_pkg;

  // field widths
  localparam int CountW   = 32;
  localparam int TimeW    = 63;
  localparam int IntvW    = 48;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 48;
  localparam int DivCntW  = $clog2(TimeW);

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegCapacity = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegInterval = CfgIdxW'(1);

  // operation codes
  localparam logic OpObtain = 1'b0;
  localparam logic OpDrain  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } tbrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } tbrl_stat_t;

endpackage

// File: rtl/core/tbrl_ctrl.sv
`timescale 1ns / 1ps

module tbrl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tbrl_pkg::tbrl_stat_t stat_i,
  output tbrl_pkg::tbrl_cmd_t  cmd_o
);
  import tbrl_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.need_div ? StDiv : StDone;
        end
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        if (stat_i.div_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/tbrl_dp.sv
`timescale 1ns / 1ps

module tbrl_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tbrl_pkg::tbrl_cmd_t               cmd_i,
  output tbrl_pkg::tbrl_stat_t              stat_o,
  input  logic                              operation_i,
  input  logic [tbrl_pkg::TimeW-1:0]        timestamp_i,
  input  logic                              cfg_valid_i,
  input  logic [tbrl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tbrl_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              granted_o,
  output logic [tbrl_pkg::CountW-1:0]       tokens_left_o
);
  import tbrl_pkg::*;

  // configuration and bucket state
  logic [CountW-1:0] cap_q, cap_d;
  logic [IntvW-1:0]  intv_q, intv_d;
  logic [CountW-1:0] tok_q, tok_d;
  logic [TimeW-1:0]  last_q, last_d;

  // captured item and divider
  logic              op_q;
  logic [TimeW-1:0]  now_q;
  logic [TimeW-1:0]  quo_q;
  logic [IntvW-1:0]  rem_q;
  logic [DivCntW-1:0] cnt_q;

  // output register
  logic              out_valid_q;
  logic              gnt_q;
  logic [CountW-1:0] out_tok_q;

  logic [IntvW:0]    shift_w;
  logic [IntvW+1:0]  trial_w;
  logic              borrow_w;
  logic [CountW-1:0] room_w;
  logic              add_ge_room_w;
  logic [CountW-1:0] tok_ref_w;
  logic              gnt_w;
  logic [CountW-1:0] cfg_cap_w;

  // status toward the controller
  assign stat_o.need_div = (operation_i == OpObtain) && (timestamp_i > last_q) &&
                           (intv_q != '0);
  assign stat_o.div_last = (cnt_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // one restoring step: shift a dividend bit into the remainder
  assign shift_w  = {rem_q, quo_q[TimeW-1]};
  assign trial_w  = {1'b0, shift_w} - {2'b00, intv_q};
  assign borrow_w = trial_w[IntvW+1];

  // room left in the bucket and refill decision
  assign room_w        = cap_q - tok_q;
  assign add_ge_room_w = (|quo_q[TimeW-1:CountW]) || (quo_q[CountW-1:0] >= room_w);
  assign cfg_cap_w     = cfg_data_i[CountW-1:0];

  // bucket update at commit and on configuration writes
  always_comb begin
    cap_d     = cap_q;
    intv_d    = intv_q;
    tok_d     = tok_q;
    last_d    = last_q;
    tok_ref_w = tok_q;
    gnt_w     = 1'b0;
    if (cmd_i.commit) begin
      if (op_q == OpDrain) begin
        tok_d  = '0;
        last_d = now_q;
      end else begin
        // lazy refill
        if (now_q < last_q) begin
          last_d = now_q;
        end else if ((now_q != last_q) && (intv_q != '0) && (quo_q != '0)) begin
          if ((tok_q >= cap_q) || add_ge_room_w) begin
            last_d = now_q;
            if (tok_q < cap_q) begin
              tok_ref_w = cap_q;
            end
          end else begin
            tok_ref_w = tok_q + quo_q[CountW-1:0];
            last_d    = now_q - {{(TimeW-IntvW){1'b0}}, rem_q};
          end
        end
        // take one token if there is one; a zero interval grants without taking one
        tok_d = tok_ref_w;
        if (intv_q == '0) begin
          gnt_w = 1'b1;
        end else if (tok_ref_w != '0) begin
          tok_d = tok_ref_w - CountW'(1);
          gnt_w = 1'b1;
        end
      end
    end else if (cfg_valid_i) begin
      if ((cfg_index_i == RegCapacity) && (cfg_cap_w != '0)) begin
        cap_d = cfg_cap_w;
        if (tok_q > cfg_cap_w) begin
          tok_d = cfg_cap_w;
        end
      end else if (cfg_index_i == RegInterval) begin
        intv_d = cfg_data_i[IntvW-1:0];
      end
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CountW'(1);
      intv_q      <= '0;
      tok_q       <= CountW'(1);
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q  <= cap_d;
      intv_q <= intv_d;
      tok_q  <= tok_d;
      last_q <= last_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture, divider and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      now_q <= timestamp_i;
      quo_q <= timestamp_i - last_q;
      rem_q <= '0;
      cnt_q <= DivCntW'(TimeW - 1);
    end else if (cmd_i.step) begin
      quo_q <= {quo_q[TimeW-2:0], !borrow_w};
      rem_q <= borrow_w ? shift_w[IntvW-1:0] : trial_w[IntvW-1:0];
      cnt_q <= cnt_q - DivCntW'(1);
    end
    if (cmd_i.commit) begin
      gnt_q     <= gnt_w;
      out_tok_q <= tok_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign granted_o     = gnt_q;
  assign tokens_left_o = out_tok_q;

endmodule

// File: rtl/core/token_bucket_rate_limiter.sv
`timescale 1ns / 1ps
// channel   direction  signals
// -------   ---------  ---------------------------------------------------
// in        input      in_valid_i / in_ready_o, operation_i, timestamp_i
// out       output     out_valid_o / out_ready_i, granted_o, tokens_left_o
// cfg       input      cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i
//
// an obtain with elapsed time and a nonzero interval passes through accept,
// the one-bit-per-cycle restoring divider and commit; a drain, or an obtain
// with no elapsed time or unlimited rate, goes from accept straight to commit.
// reset leaves one token, capacity 1, interval 0 and refill time 0.
// the result sits in an output register; the next item is accepted while it
// waits, and the commit of that item waits until the register is free.

module token_bucket_rate_limiter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [tbrl_pkg::TimeW-1:0]    timestamp_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          granted_o,
  output logic [tbrl_pkg::CountW-1:0]   tokens_left_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tbrl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tbrl_pkg::CfgDataW-1:0] cfg_data_i
);
  import tbrl_pkg::*;

  tbrl_cmd_t  cmd_w;
  tbrl_stat_t stat_w;

  // the user writes registers only while idle with no item offered (cfg_ready_o); the block does not enforce it
  assign cfg_ready_o = in_ready_o && !in_valid_i;

  // sequencer
  tbrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat_w),
    .cmd_o      (cmd_w)
  );

  // bucket state, divider and result register
  tbrl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_w),
    .stat_o        (stat_w),
    .operation_i   (operation_i),
    .timestamp_i   (timestamp_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .granted_o     (granted_o),
    .tokens_left_o (tokens_left_o)
  );

  // one item in flight: no new item right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  // a result appears only from the commit state
  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result produced without an item in flight");

  // commit never comes in the accept cycle itself
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
    else $error("result produced in the accept cycle");

endmodule

// File: dv/token_bucket_rate_limiter_tb.sv
`timescale 1ns / 1ps

module token_bucket_rate_limiter_tb;
  import tbrl_pkg::*;

  localparam int PhaseItems = 200;
  localparam int NumPhases  = 8;
  localparam int IdleGap    = 4;
  localparam int DrainWait  = 70;

  // register indexes the block does not decode
  localparam logic [CfgIdxW-1:0] RegSpare2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpare3 = CfgIdxW'(3);

  typedef struct packed {
    logic              granted;
    logic [CountW-1:0] tokens;
  } bucket_res_t;

  typedef enum logic {RowItem, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               op;
    logic [CfgIdxW-1:0] idx;
    logic [TimeW-1:0]   val;
    logic               typed;
    bucket_res_t        want;
  } dir_row_t;

  localparam bucket_res_t NoWant = '0;
  localparam int NumDirRows = 24;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic                operation_i   = OpObtain;
  logic [TimeW-1:0]    timestamp_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic                granted_o;
  logic [CountW-1:0]   tokens_left_o;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = RegCapacity;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // bucket state as the block should hold it
  logic [CountW-1:0] bkt_cap    = 1;
  logic [IntvW-1:0]  bkt_intv   = '0;
  logic [CountW-1:0] bkt_tokens = 1;
  logic [TimeW-1:0]  bkt_last   = '0;

  bucket_res_t pending_res[$];
  dir_row_t    dir_tbl [NumDirRows];

  bit no_idle    = 1'b0;
  int stall_left = 0;
  int n_items    = 0;
  int n_drains   = 0;
  int n_grants   = 0;
  int n_denials  = 0;
  int n_regs     = 0;
  int n_checked  = 0;
  int n_errors   = 0;

  token_bucket_rate_limiter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .timestamp_i   (timestamp_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .granted_o     (granted_o),
    .tokens_left_o (tokens_left_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] rand_bits64();
    return {$urandom, $urandom};
  endfunction

  // drain, or lazy refill then obtain
  function automatic bucket_res_t predict_bucket(input logic op, input logic [TimeW-1:0] now);
    logic [TimeW-1:0]  elapsed;
    logic [63:0]       credit;
    logic [63:0]       span;
    logic [CountW-1:0] room;
    bucket_res_t       res;
    res.granted = 1'b0;
    if (op == OpDrain) begin
      bkt_tokens = '0;
      bkt_last   = now;
    end else begin
      if (now < bkt_last) begin
        // clock went backwards: resync only
        bkt_last = now;
      end else if (now != bkt_last && bkt_intv != '0) begin
        elapsed = now - bkt_last;
        credit  = {1'b0, elapsed} / {16'b0, bkt_intv};
        if (credit != 0) begin
          if (bkt_tokens >= bkt_cap) begin
            bkt_last = now;
          end else begin
            room = bkt_cap - bkt_tokens;
            if (credit >= {32'b0, room}) begin
              bkt_last   = now;
              bkt_tokens = bkt_cap;
            end else begin
              // below the cap the refill time moves by whole intervals
              bkt_tokens = bkt_tokens + credit[CountW-1:0];
              span       = credit * {16'b0, bkt_intv};
              bkt_last   = bkt_last + span[TimeW-1:0];
            end
          end
        end
      end
      if (bkt_intv == '0) begin
        res.granted = 1'b1;
      end else if (bkt_tokens != '0) begin
        bkt_tokens  = bkt_tokens - 1'b1;
        res.granted = 1'b1;
      end
    end
    res.tokens = bkt_tokens;
    return res;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    if (idx == RegCapacity) begin
      // zero capacity is dropped, otherwise stored tokens clamp
      if (data[CountW-1:0] != '0) begin
        bkt_cap = data[CountW-1:0];
        if (bkt_tokens > bkt_cap) bkt_tokens = bkt_cap;
      end
    end else if (idx == RegInterval) begin
      bkt_intv = data[IntvW-1:0];
    end
  endfunction

  // register write, only once the block has gone quiet
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (IdleGap) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    n_regs++;
    cfg_valid_i <= 1'b0;
  endtask

  // offer one item; valid is left high after acceptance
  task automatic offer_request(input logic op, input logic [TimeW-1:0] ts,
                               input logic typed, input bucket_res_t want);
    bucket_res_t got;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    timestamp_i <= ts;
    do @(posedge clk_i); while (!in_ready_o);
    got = predict_bucket(op, ts);
    if (typed) got = want;
    pending_res.push_back(got);
    n_items++;
    if (op == OpDrain) n_drains++;
    else if (got.granted) n_grants++;
    else n_denials++;
  endtask

  // result side: check against the oldest expectation, stall in bursts
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin : chk
      bucket_res_t want;
      n_checked++;
      if (pending_res.size() == 0) begin
        n_errors++;
        $display("%0t: result with none expected: granted %0b tokens %0d",
                 $time, granted_o, tokens_left_o);
      end else begin
        want = pending_res.pop_front();
        if (granted_o !== want.granted) begin
          n_errors++;
          $display("%0t: granted expected %0b actual %0b", $time, want.granted, granted_o);
        end
        if (tokens_left_o !== want.tokens) begin
          n_errors++;
          $display("%0t: tokens_left expected %0d actual %0d",
                   $time, want.tokens, tokens_left_o);
        end
      end
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    logic [TimeW-1:0]  cur_ts;
    logic [63:0]       k;
    logic [63:0]       delta;
    logic [63:0]       back;
    logic [CountW-1:0] cap_v;
    logic [IntvW-1:0]  intv_v;
    logic              op;
    int                pick;

    dir_tbl = '{
      // reset state: unlimited, one token
      '{RowItem, OpObtain, RegCapacity, 63'd0, 1'b1, '{1'b1, 32'd1}},
      '{RowItem, OpDrain,  RegCapacity, 63'd5, 1'b1, '{1'b0, 32'd0}},
      '{RowItem, OpObtain, RegCapacity, 63'd6, 1'b1, '{1'b1, 32'd0}},
      '{RowReg,  OpObtain, RegCapacity, 63'd3, 1'b0, NoWant},
      '{RowReg,  OpObtain, RegInterval, 63'd10, 1'b0, NoWant},
      // less than one interval: denied
      '{RowItem, OpObtain, RegCapacity, 63'd6, 1'b1, '{1'b0, 32'd0}},
      // one interval credited below the cap
      '{RowItem, OpObtain, RegCapacity, 63'd15, 1'b1, '{1'b1, 32'd0}},
      // time runs backwards
      '{RowItem, OpObtain, RegCapacity, 63'd3, 1'b1, '{1'b0, 32'd0}},
      // refill saturates
      '{RowItem, OpObtain, RegCapacity, 63'd1000, 1'b1, '{1'b1, 32'd2}},
      '{RowItem, OpObtain, RegCapacity, 63'd1025, 1'b0, NoWant},
      // zero capacity ignored, spare indexes do nothing
      '{RowReg,  OpObtain, RegCapacity, 63'h0000_ABCD_0000_0000, 1'b0, NoWant},
      '{RowReg,  OpObtain, RegSpare2,   63'h0000_FFFF_FFFF_FFFF, 1'b0, NoWant},
      '{RowReg,  OpObtain, RegSpare3,   63'h0000_5A5A_A5A5_5A5A, 1'b0, NoWant},
      // capacity write clamps the stored tokens
      '{RowReg,  OpObtain, RegCapacity, 63'd1, 1'b0, NoWant},
      '{RowItem, OpObtain, RegCapacity, 63'd1025, 1'b1, '{1'b1, 32'd0}},
      '{RowReg,  OpObtain, RegCapacity, 63'h0000_FFFF_FFFF_FFFF, 1'b0, NoWant},
      '{RowReg,  OpObtain, RegInterval, 63'd1, 1'b0, NoWant},
      '{RowItem, OpObtain, RegCapacity, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1,
        '{1'b1, 32'hFFFF_FFFE}},
      '{RowItem, OpObtain, RegCapacity, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1,
        '{1'b1, 32'hFFFF_FFFD}},
      '{RowItem, OpDrain,  RegCapacity, 63'd0, 1'b1, '{1'b0, 32'd0}},
      '{RowReg,  OpObtain, RegInterval, 63'h0000_FFFF_FFFF_FFFF, 1'b0, NoWant},
      '{RowItem, OpObtain, RegCapacity, 63'h0000_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 32'd0}},
      '{RowItem, OpObtain, RegCapacity, 63'h0001_FFFF_FFFF_FFFD, 1'b0, NoWant},
      '{RowItem, OpDrain,  RegCapacity, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 32'd0}}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (dir_tbl[r]) begin
      if (dir_tbl[r].kind == RowReg) begin
        write_reg(dir_tbl[r].idx, dir_tbl[r].val[CfgDataW-1:0]);
      end else begin
        offer_request(dir_tbl[r].op, dir_tbl[r].val, dir_tbl[r].typed, dir_tbl[r].want);
      end
    end

    // random phases, one setting each
    cur_ts = bkt_last;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin cap_v = 4;  intv_v = 100; end
        1: begin cap_v = 1;  intv_v = 1; end
        2: begin cap_v = '1; intv_v = '1; end
        3: begin cap_v = $urandom_range(2, 16); intv_v = IntvW'($urandom_range(1, 1000)); end
        4: begin cap_v = $urandom_range(1, 8);  intv_v = '0; end
        5: begin cap_v = $urandom_range(1, 8);  intv_v = IntvW'(rand_bits64()); end
        6: begin cap_v = '1; intv_v = IntvW'($urandom_range(1, 50)); end
        default: begin cap_v = 3; intv_v = 7; end
      endcase
      write_reg(RegCapacity, {16'($urandom), {CountW{1'b0}}});
      write_reg(($urandom_range(0, 1) == 0) ? RegSpare2 : RegSpare3, CfgDataW'(rand_bits64()));
      write_reg(RegCapacity, {16'($urandom), cap_v});
      write_reg(RegInterval, intv_v);
      if (ph == NumPhases - 1) no_idle = 1'b1;

      for (int i = 0; i < PhaseItems; i++) begin
        // hold off until every result is back
        if (i == PhaseItems / 2 && !no_idle) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (pending_res.size() != 0);
        end
        pick = $urandom_range(0, 99);
        op   = ($urandom_range(0, 11) == 0) ? OpDrain : OpObtain;
        if (pick < 8) begin
          // noise: any time, either operation
          cur_ts = TimeW'(rand_bits64());
          op     = 1'($urandom_range(0, 1));
        end else if (pick < 16) begin
          // time runs backwards
          back = {32'b0, $urandom_range(1, 1000)} * {16'b0, intv_v} +
                 64'($urandom_range(1, 9));
          cur_ts = (back > {1'b0, cur_ts}) ? '0 : cur_ts - back[TimeW-1:0];
        end else if (pick >= 26) begin
          // forward by whole intervals plus a remainder
          pick = $urandom_range(0, 19);
          if (pick == 0) k = {32'b0, $urandom};
          else if (pick < 4) k = 64'($urandom_range(3, 5000));
          else k = 64'($urandom_range(0, 2));
          if (intv_v == '0) delta = k + 64'($urandom_range(0, 3));
          else delta = k * {16'b0, intv_v} + rand_bits64() % {16'b0, intv_v};
          cur_ts = cur_ts + delta[TimeW-1:0];
        end
        offer_request(op, cur_ts, 1'b0, NoWant);
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_res.size() != 0);
    repeat (DrainWait) @(posedge clk_i);

    $display("ran %0d requests (%0d drains, %0d grants, %0d denials), %0d results checked",
             n_items, n_drains, n_grants, n_denials, n_checked);
    $display("%0d register writes: unit and full-width capacity and interval, unlimited mode",
             n_regs);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("run limit reached with %0d results outstanding", pending_res.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
